FILE: sv/trp_pkg.sv
// Package for the turbo RSC pair encoder: field widths, register indexes,
// reset values and input kind codes. No dependencies.
package trp_pkg;

    localparam int GEN_W      = 8;
    localparam int NUM_GEN    = 4;
    localparam int PAR_W      = 4;
    localparam int NUMOUT_W   = 3;
    localparam int CLEN_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef logic [GEN_W-1:0]      gen_t;
    typedef logic [PAR_W-1:0]      par_t;
    typedef logic [NUMOUT_W-1:0]   numout_t;
    typedef logic [CLEN_W-1:0]     clen_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam cfg_idx_t REG_GEN_REC        = 3'd0;
    localparam cfg_idx_t REG_GEN_OUT_A      = 3'd1;
    localparam cfg_idx_t REG_GEN_OUT_B      = 3'd2;
    localparam cfg_idx_t REG_GEN_OUT_C      = 3'd3;
    localparam cfg_idx_t REG_GEN_OUT_D      = 3'd4;
    localparam cfg_idx_t REG_NUM_OUTPUTS    = 3'd5;
    localparam cfg_idx_t REG_CONSTRAINT_LEN = 3'd6;

    localparam gen_t    GEN_REC_RST   = 8'd13;
    localparam gen_t    GEN_OUT_A_RST = 8'd11;
    localparam gen_t    GEN_OUT_RST   = 8'd0;
    localparam numout_t NUM_OUT_RST   = 3'd1;
    localparam clen_t   CLEN_RST      = 4'd4;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TERM = 1'b1;

endpackage

FILE: sv/trp_item_if.sv
// Input request channel of the turbo RSC pair encoder.
// Depends on nothing.
interface trp_item_if;
    logic valid;
    logic ready;
    logic kind;
    logic data_bit;
    logic interleaved_bit;

    modport source (output valid, kind, data_bit, interleaved_bit, input ready);
    modport sink   (input valid, kind, data_bit, interleaved_bit, output ready);
endinterface

FILE: sv/trp_result_if.sv
// Result channel of the turbo RSC pair encoder.
// Depends on trp_pkg.
interface trp_result_if;
    logic          valid;
    logic          ready;
    logic          systematic_bit;
    trp_pkg::par_t parity_first;
    trp_pkg::par_t parity_second;
    logic          is_tail;
    logic          last;

    modport source (output valid, systematic_bit, parity_first, parity_second, is_tail, last,
                    input ready);
    modport sink   (input valid, systematic_bit, parity_first, parity_second, is_tail, last,
                    output ready);
endinterface

FILE: sv/trp_cfg_if.sv
// Configuration write channel of the turbo RSC pair encoder.
// Depends on trp_pkg.
interface trp_cfg_if;
    logic               valid;
    logic               ready;
    trp_pkg::cfg_idx_t  index;
    trp_pkg::cfg_data_t data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/turbo_rsc_pair_encoder_core.sv
// Turbo RSC pair encoder top level: two recursive systematic encoders with
// shared generator masks. Depends on trp_pkg and the three trp_*_if interfaces.
//
// Channels: cfg writes generator masks, output count and constraint length
// (always ready; write only while idle). item takes data or terminate
// requests; result gives one result per data request and K-1 tail results
// per terminate request, last marking the final one.
// Flow: a request is registered in the input register on acceptance, and its
// first result is loaded into the result register once that register is
// empty or being taken.
// Throughput: one data request per cycle while result does not stall. A
// terminate request holds the input register until its K-1 tail results
// have been produced, then both encoder states clear.
// Reset: configuration returns to its defaults, states clear, no result.
// Stall: when result is not taken the result register holds; the input
// register still takes one request, after which item.ready drops.
module turbo_rsc_pair_encoder_core #(
    parameter int MAX_CONSTRAINT = 8,
    parameter int MAX_OUTPUTS    = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    trp_cfg_if.sink      cfg,
    trp_item_if.sink     item,
    trp_result_if.source result
);

    localparam int MW   = MAX_CONSTRAINT;
    localparam int SW   = MW - 1;
    localparam int GW   = (MW > trp_pkg::GEN_W) ? MW : trp_pkg::GEN_W;
    localparam int KW   = $clog2(MAX_CONSTRAINT + 1);
    localparam int KCW  = (KW > trp_pkg::CLEN_W) ? KW : trp_pkg::CLEN_W;
    localparam int TW   = $clog2(MAX_CONSTRAINT);
    localparam int NLIM = (MAX_OUTPUTS < trp_pkg::NUM_GEN) ? MAX_OUTPUTS : trp_pkg::NUM_GEN;
    localparam int NG   = trp_pkg::NUM_GEN;
    localparam int PW   = trp_pkg::PAR_W;

    // configuration
    trp_pkg::gen_t    gen_rec_reg;
    trp_pkg::gen_t    gen_out_reg [NG];
    trp_pkg::numout_t num_outputs_reg;
    trp_pkg::clen_t   constraint_len_reg;

    // input stage and encoder state
    logic          s1_valid_reg;
    logic          s1_kind_reg;
    logic          s1_d_reg;
    logic          s1_e_reg;
    logic [TW-1:0] tail_cnt_reg;
    logic [SW-1:0] tail_c_reg;
    logic [SW-1:0] first_state_reg;
    logic [SW-1:0] second_state_reg;

    // result stage
    logic          res_valid_reg;
    logic          res_sys_reg;
    trp_pkg::par_t res_p1_reg;
    trp_pkg::par_t res_p2_reg;
    logic          res_tail_reg;
    logic          res_last_reg;

    logic [KCW-1:0]         clen_w;
    logic [KW-1:0]          k_eff;
    trp_pkg::numout_t       n_eff;
    logic [MW-1:0]          top_mask;
    logic [MW-1:0]          low_mask;
    logic [MW-1:0]          rec_m;
    logic [NG-1:0][MW-1:0]  gen_m;
    logic [PW-1:0]          par_en;
    logic                   advance;
    logic                   is_term;
    logic                   tail_last;
    logic                   consume;
    logic [SW-1:0]          tail_c;
    logic                   tail_bit;
    logic                   bit_first;
    logic                   bit_second;
    logic [SW+PW-1:0]       step_first;
    logic [SW+PW-1:0]       step_second;

    function automatic logic [SW+PW-1:0] rsc_step(
        input logic [SW-1:0]         st,
        input logic                  b,
        input logic [MW-1:0]         top,
        input logic [MW-1:0]         low,
        input logic [MW-1:0]         rec,
        input logic [NG-1:0][MW-1:0] gens,
        input logic [PW-1:0]         en
    );
        logic [MW-1:0] st_w;
        logic [MW-1:0] all_w;
        logic [MW-1:0] mem;
        logic          fb;
        logic [PW-1:0] p;
        st_w  = MW'(st) & low;
        all_w = st_w | (b ? top : '0);
        fb    = ^(rec & all_w);
        mem   = st_w | (fb ? top : '0);
        for (int j = 0; j < PW; j++)
        begin
            p[j] = en[j] & (^(gens[j] & mem));
        end
        return {mem[MW-1:1], p};
    endfunction

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_rec_reg        <= trp_pkg::GEN_REC_RST;
            gen_out_reg[0]     <= trp_pkg::GEN_OUT_A_RST;
            for (int j = 1; j < NG; j++)
            begin
                gen_out_reg[j] <= trp_pkg::GEN_OUT_RST;
            end
            num_outputs_reg    <= trp_pkg::NUM_OUT_RST;
            constraint_len_reg <= trp_pkg::CLEN_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                trp_pkg::REG_GEN_REC:        gen_rec_reg    <= cfg.data;
                trp_pkg::REG_GEN_OUT_A:      gen_out_reg[0] <= cfg.data;
                trp_pkg::REG_GEN_OUT_B:      gen_out_reg[1] <= cfg.data;
                trp_pkg::REG_GEN_OUT_C:      gen_out_reg[2] <= cfg.data;
                trp_pkg::REG_GEN_OUT_D:      gen_out_reg[3] <= cfg.data;
                trp_pkg::REG_NUM_OUTPUTS:    num_outputs_reg <= cfg.data[trp_pkg::NUMOUT_W-1:0];
                trp_pkg::REG_CONSTRAINT_LEN:
                    constraint_len_reg <= cfg.data[trp_pkg::CLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped K and output count, masks widened to the memory word
    always_comb
    begin
        clen_w = KCW'(constraint_len_reg);
        priority if (clen_w < KCW'(2))
            k_eff = KW'(2);
        else if (clen_w > KCW'(MAX_CONSTRAINT))
            k_eff = KW'(MAX_CONSTRAINT);
        else
            k_eff = clen_w[KW-1:0];

        priority if (num_outputs_reg == '0)
            n_eff = trp_pkg::numout_t'(1);
        else if (num_outputs_reg > trp_pkg::numout_t'(NLIM))
            n_eff = trp_pkg::numout_t'(NLIM);
        else
            n_eff = num_outputs_reg;

        for (int j = 0; j < PW; j++)
        begin
            par_en[j] = trp_pkg::numout_t'(j) < n_eff;
        end

        top_mask = MW'(1) << (k_eff - KW'(1));
        low_mask = top_mask - MW'(1);
        rec_m    = MW'(GW'(gen_rec_reg));
        for (int j = 0; j < NG; j++)
        begin
            gen_m[j] = MW'(GW'(gen_out_reg[j]));
        end
    end

    always_comb
    begin
        advance   = s1_valid_reg && (!res_valid_reg || result.ready);
        is_term   = s1_kind_reg == trp_pkg::KIND_TERM;
        tail_last = KW'(tail_cnt_reg) == (k_eff - KW'(2));
        consume   = advance && (!is_term || tail_last);
        tail_c    = (tail_cnt_reg == '0) ? (first_state_reg & low_mask[SW-1:0]) : tail_c_reg;
        tail_bit  = (tail_c != '0) && !(^(rec_m & (MW'(tail_c) | top_mask)));
        bit_first  = is_term ? tail_bit : s1_d_reg;
        bit_second = is_term ? tail_bit : s1_e_reg;
        step_first  = rsc_step(first_state_reg, bit_first, top_mask, low_mask, rec_m,
                               gen_m, par_en);
        step_second = rsc_step(second_state_reg, bit_second, top_mask, low_mask, rec_m,
                               gen_m, par_en);
    end

    assign item.ready = !s1_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            tail_cnt_reg     <= '0;
            first_state_reg  <= '0;
            second_state_reg <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (item.valid && item.ready)
                s1_valid_reg <= 1'b1;
            else if (consume)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                if (is_term && consume)
                begin
                    first_state_reg  <= '0;
                    second_state_reg <= '0;
                end
                else
                begin
                    first_state_reg  <= step_first[SW+PW-1:PW];
                    second_state_reg <= step_second[SW+PW-1:PW];
                end
                if (is_term)
                    tail_cnt_reg <= consume ? '0 : tail_cnt_reg + TW'(1);
            end

            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_kind_reg <= item.kind;
            s1_d_reg    <= item.data_bit;
            s1_e_reg    <= item.interleaved_bit;
        end
        if (advance)
        begin
            tail_c_reg   <= tail_c >> 1;
            res_sys_reg  <= bit_first;
            res_p1_reg   <= step_first[PW-1:0];
            res_p2_reg   <= step_second[PW-1:0];
            res_tail_reg <= is_term;
            res_last_reg <= !is_term || tail_last;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.systematic_bit = res_sys_reg;
    assign result.parity_first   = res_p1_reg;
    assign result.parity_second  = res_p2_reg;
    assign result.is_tail        = res_tail_reg;
    assign result.last           = res_last_reg;

    a_data_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_tail_reg |-> res_last_reg)
        else $error("data result without last");

    a_tail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        consume && is_term |=> first_state_reg == '0 && second_state_reg == '0)
        else $error("states not cleared after tail");

    a_tail_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_term && !tail_last |=> s1_valid_reg && tail_cnt_reg != '0)
        else $error("terminate request left before tail finished");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> item.ready)
        else $error("input stage empty but not ready");

endmodule

FILE: tb/tb_turbo_rsc_pair_encoder_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for turbo_rsc_pair_encoder_core: a queue-fed request driver, a
// result monitor and a bit-level predictor of both RSC encoders and their termination tail.
// Depends on trp_pkg, the trp_*_if interfaces and the core itself.
module tb_turbo_rsc_pair_encoder_core;

    localparam int ENC_MAX_K  = 8;
    localparam int ENC_MAX_N  = 4;
    localparam int NUM_PHASES = 9;
    localparam int PHASE_REQS = 18;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic kind;
        logic data_bit;
        logic ilv_bit;
    } enc_request_t;

    typedef struct packed {
        logic          sys;
        trp_pkg::par_t par_a;
        trp_pkg::par_t par_b;
        logic          tail;
        logic          last;
    } enc_result_t;

    logic clk = 1'b0;
    logic rst_n;

    trp_cfg_if    cfg_ch ();
    trp_item_if   item_ch ();
    trp_result_if res_ch ();

    turbo_rsc_pair_encoder_core #(
        .MAX_CONSTRAINT (ENC_MAX_K),
        .MAX_OUTPUTS    (ENC_MAX_N)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (res_ch)
    );

    // predictor copy of configuration and encoder states
    trp_pkg::gen_t    gen_rec_m = trp_pkg::GEN_REC_RST;
    trp_pkg::gen_t    gen_out_m [trp_pkg::NUM_GEN] = '{trp_pkg::GEN_OUT_A_RST,
        trp_pkg::GEN_OUT_RST, trp_pkg::GEN_OUT_RST, trp_pkg::GEN_OUT_RST};
    trp_pkg::numout_t num_out_m = trp_pkg::NUM_OUT_RST;
    trp_pkg::clen_t   clen_m    = trp_pkg::CLEN_RST;
    logic [6:0]       first_st  = '0;
    logic [6:0]       second_st = '0;

    enc_request_t pending_items [$];
    enc_result_t  expected_results [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    int mismatch_count    = 0;
    int requests_accepted = 0;
    int terms_queued      = 0;
    int results_checked   = 0;
    int tail_results      = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int eff_constraint();
        int k;
        k = int'(clen_m);
        if (k < 2) k = 2;
        if (k > ENC_MAX_K) k = ENC_MAX_K;
        return k;
    endfunction

    function automatic int eff_outputs();
        int n;
        n = int'(num_out_m);
        if (n < 1) n = 1;
        if (n > ENC_MAX_N) n = ENC_MAX_N;
        if (n > trp_pkg::NUM_GEN) n = trp_pkg::NUM_GEN;
        return n;
    endfunction

    function automatic void rsc_advance(input logic [6:0] st_in, input logic b, input int k,
                                        output logic [6:0] st_out, output trp_pkg::par_t par);
        logic [7:0] top;
        logic [7:0] st;
        logic [7:0] mem;
        logic       fb;
        int         n;
        top = 8'd1 << (k - 1);
        st  = {1'b0, st_in} & (top - 8'd1);
        fb  = ^(gen_rec_m & (st | (b ? top : 8'd0)));
        mem = st | (fb ? top : 8'd0);
        n   = eff_outputs();
        par = '0;
        for (int j = 0; j < n; j++)
            par[j] = ^(gen_out_m[j] & mem);
        st_out = mem[7:1];
    endfunction

    task automatic predict_request(input logic kind, input logic d, input logic e);
        int          k;
        logic [7:0]  top;
        logic [7:0]  s0;
        logic [7:0]  c;
        logic        tb;
        enc_result_t r;
        k = eff_constraint();
        if (kind == trp_pkg::KIND_DATA) begin
            rsc_advance(first_st, d, k, first_st, r.par_a);
            rsc_advance(second_st, e, k, second_st, r.par_b);
            r.sys  = d;
            r.tail = 1'b0;
            r.last = 1'b1;
            expected_results.push_back(r);
        end else begin
            top = 8'd1 << (k - 1);
            s0  = {1'b0, first_st} & (top - 8'd1);
            for (int i = 0; i < k - 1; i++) begin
                c  = s0 >> i;
                tb = (c != 8'd0) && !(^(gen_rec_m & (c | top)));
                rsc_advance(first_st, tb, k, first_st, r.par_a);
                rsc_advance(second_st, tb, k, second_st, r.par_b);
                r.sys  = tb;
                r.tail = 1'b1;
                r.last = (i == k - 2);
                expected_results.push_back(r);
            end
            first_st  = '0;
            second_st = '0;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [3:0] got,
                                   input logic [3:0] want);
        mismatch_count++;
        $display("MISMATCH at result %0d, %s: got %h, expected %h",
                 results_checked, field, got, want);
    endtask

    task automatic push_request(input logic kind, input logic d, input logic e);
        enc_request_t q;
        q.kind     = kind;
        q.data_bit = d;
        q.ilv_bit  = e;
        pending_items.push_back(q);
        if (kind == trp_pkg::KIND_TERM) terms_queued++;
    endtask

    task automatic cfg_write(input trp_pkg::cfg_idx_t idx, input trp_pkg::cfg_data_t val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            trp_pkg::REG_GEN_REC:        gen_rec_m    = val;
            trp_pkg::REG_GEN_OUT_A:      gen_out_m[0] = val;
            trp_pkg::REG_GEN_OUT_B:      gen_out_m[1] = val;
            trp_pkg::REG_GEN_OUT_C:      gen_out_m[2] = val;
            trp_pkg::REG_GEN_OUT_D:      gen_out_m[3] = val;
            trp_pkg::REG_NUM_OUTPUTS:    num_out_m    = val[trp_pkg::NUMOUT_W-1:0];
            trp_pkg::REG_CONSTRAINT_LEN: clen_m       = val[trp_pkg::CLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_items.size() != 0 || item_ch.valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin : drive_requests
        enc_request_t nxt;
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                predict_request(item_ch.kind, item_ch.data_bit, item_ch.interleaved_bit);
                requests_accepted++;
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = pending_items.pop_front();
                    item_ch.valid           <= 1'b1;
                    item_ch.kind            <= nxt.kind;
                    item_ch.data_bit        <= nxt.data_bit;
                    item_ch.interleaved_bit <= nxt.ilv_bit;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin : hold_counter
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req && !hold_done) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        enc_result_t got;
        enc_result_t want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.sys   = res_ch.systematic_bit;
                got.par_a = res_ch.parity_first;
                got.par_b = res_ch.parity_second;
                got.tail  = res_ch.is_tail;
                got.last  = res_ch.last;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", 4'(got.sys), 4'hx);
                end else begin
                    want = expected_results.pop_front();
                    if (got.sys !== want.sys)
                        report_mismatch("systematic_bit", 4'(got.sys), 4'(want.sys));
                    if (got.par_a !== want.par_a)
                        report_mismatch("parity_first", got.par_a, want.par_a);
                    if (got.par_b !== want.par_b)
                        report_mismatch("parity_second", got.par_b, want.par_b);
                    if (got.tail !== want.tail)
                        report_mismatch("is_tail", 4'(got.tail), 4'(want.tail));
                    if (got.last !== want.last)
                        report_mismatch("last", 4'(got.last), 4'(want.last));
                    if (want.tail) tail_results++;
                end
                results_checked++;
            end
            res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #10_000_000;
        $display("Timeout: %0d results still expected", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        trp_pkg::cfg_data_t cfg_vals [7];
        int                 blk_left;
        rst_n                   = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = trp_pkg::REG_GEN_REC;
        cfg_ch.data             = '0;
        item_ch.valid           = 1'b0;
        item_ch.kind            = trp_pkg::KIND_DATA;
        item_ch.data_bit        = 1'b0;
        item_ch.interleaved_bit = 1'b0;
        res_ch.ready            = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests at reset configuration
        tx_idle_pct = 23;
        rx_idle_pct = 78;
        push_request(trp_pkg::KIND_TERM, 1'b0, 1'b0);   // tail from all-zero state
        push_request(trp_pkg::KIND_DATA, 1'b0, 1'b0);
        push_request(trp_pkg::KIND_DATA, 1'b1, 1'b1);
        push_request(trp_pkg::KIND_DATA, 1'b1, 1'b0);
        push_request(trp_pkg::KIND_DATA, 1'b0, 1'b1);
        push_request(trp_pkg::KIND_TERM, 1'b1, 1'b1);   // ignored data fields
        push_request(trp_pkg::KIND_DATA, 1'b1, 1'b1);
        push_request(trp_pkg::KIND_DATA, 1'b1, 1'b1);
        push_request(trp_pkg::KIND_DATA, 1'b1, 1'b1);
        push_request(trp_pkg::KIND_DATA, 1'b1, 1'b1);
        push_request(trp_pkg::KIND_TERM, 1'b0, 1'b1);
        push_request(trp_pkg::KIND_TERM, 1'b1, 1'b0);   // back-to-back terminate
        push_request(trp_pkg::KIND_DATA, 1'b1, 1'b0);
        push_request(trp_pkg::KIND_DATA, 1'b0, 1'b0);
        push_request(trp_pkg::KIND_DATA, 1'b0, 1'b1);
        push_request(trp_pkg::KIND_DATA, 1'b1, 1'b1);
        push_request(trp_pkg::KIND_DATA, 1'b0, 1'b0);
        push_request(trp_pkg::KIND_DATA, 1'b1, 1'b0);
        push_request(trp_pkg::KIND_TERM, 1'b0, 1'b0);
        push_request(trp_pkg::KIND_DATA, 1'b1, 1'b1);   // block left open across the reconfiguration
        push_request(trp_pkg::KIND_DATA, 1'b0, 1'b1);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            for (int r = 0; r < 7; r++)
                cfg_vals[r] = trp_pkg::cfg_data_t'($urandom_range(255));
            cfg_vals[trp_pkg::REG_CONSTRAINT_LEN] = trp_pkg::cfg_data_t'($urandom_range(15));
            cfg_vals[trp_pkg::REG_NUM_OUTPUTS]    = trp_pkg::cfg_data_t'($urandom_range(7));
            case (p)
                0: begin
                    cfg_vals[trp_pkg::REG_CONSTRAINT_LEN] = 8'd2;
                    cfg_vals[trp_pkg::REG_NUM_OUTPUTS]    = 8'd1;
                end
                1: begin
                    cfg_vals[trp_pkg::REG_CONSTRAINT_LEN] = 8'd8;
                    cfg_vals[trp_pkg::REG_NUM_OUTPUTS]    = 8'd4;
                    for (int r = 0; r < 5; r++) cfg_vals[r] = 8'hff;
                end
                2: begin
                    cfg_vals[trp_pkg::REG_CONSTRAINT_LEN] = 8'd0;
                    cfg_vals[trp_pkg::REG_NUM_OUTPUTS]    = 8'd0;
                    for (int r = 0; r < 5; r++) cfg_vals[r] = 8'h00;
                end
                3: begin
                    cfg_vals[trp_pkg::REG_CONSTRAINT_LEN] = 8'hff;
                    cfg_vals[trp_pkg::REG_NUM_OUTPUTS]    = 8'hff;
                end
                4: begin
                    // feedback mask without its input tap
                    cfg_vals[trp_pkg::REG_CONSTRAINT_LEN] = 8'd8;
                    cfg_vals[trp_pkg::REG_NUM_OUTPUTS]    = 8'd5;
                    cfg_vals[trp_pkg::REG_GEN_REC]        = 8'h7f;
                end
                default: ;
            endcase
            for (int r = 0; r < 7; r++)
                cfg_write(trp_pkg::cfg_idx_t'(r), cfg_vals[r]);
            @(negedge clk);

            if (p < 3) begin
                tx_idle_pct = 23;
                rx_idle_pct = 78;
            end else if (p < 6) begin
                tx_idle_pct = 78;
                rx_idle_pct = 23;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 6) hold_req = 1'b1;

            blk_left = $urandom_range(9, 1);
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (blk_left == 0 || $urandom_range(19) == 0) begin
                    push_request(trp_pkg::KIND_TERM, 1'($urandom_range(1)),
                                 1'($urandom_range(1)));
                    blk_left = $urandom_range(9, 1);
                end else begin
                    push_request(trp_pkg::KIND_DATA, 1'($urandom_range(1)),
                                 1'($urandom_range(1)));
                    blk_left--;
                end
            end
            if (p == 6)
                wait (hold_done && hold_left == 0);
            wait_drained();
        end

        repeat (10) @(negedge clk);
        $display("Covered %0d requests (%0d terminate) over %0d register settings;",
                 requests_accepted, terms_queued, NUM_PHASES + 1);
        $display("checked %0d results, %0d of them tail results.",
                 results_checked, tail_results);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: turbo_rsc_pair_encoder_core.f
sv/trp_pkg.sv
sv/trp_item_if.sv
sv/trp_result_if.sv
sv/trp_cfg_if.sv
sv/turbo_rsc_pair_encoder_core.sv
tb/tb_turbo_rsc_pair_encoder_core.sv
